/* src/mif_pkg.sv */
package mif_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int CELL_DEPTH = MAX_ROWS << COL_W;

  localparam int STACK_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

  localparam int CFG_W = 7;
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = CFG_W'(64);
  localparam logic [CFG_ADDR_W-1:0] REG_ROW_COUNT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COL_COUNT = 1'd1;

  localparam int AREA_W = 13;
  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 16;

  localparam int CELL_W = 2;
  localparam logic [CELL_W-1:0] CELL_WATER = 2'd0;
  localparam logic [CELL_W-1:0] CELL_LAND = 2'd1;
  localparam logic [CELL_W-1:0] CELL_VISITED = 2'd2;

  localparam int NB_W = 3;
  localparam logic [NB_W-1:0] NB_DOWN = 3'd0;
  localparam logic [NB_W-1:0] NB_UP = 3'd1;
  localparam logic [NB_W-1:0] NB_RIGHT = 3'd2;
  localparam logic [NB_W-1:0] NB_LEFT = 3'd3;
  localparam logic [NB_W-1:0] NB_END = 3'd4;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP,
    ST_POP_WAIT,
    ST_NB_RD,
    ST_NB_CHK,
    ST_DONE
  } state_t;

endpackage

/* src/max_island_area_flood_fill_core.sv */
// Largest 4-connected land region of a binary grid.
// in_*: one cell per transfer in row-major order, in_tdata[0] = 1 land, 0 water.
// out_*: one transfer per grid carrying the largest region area, 0 if no land.
// cfg_*: cfg_addr 0 writes the row count, 1 the column count (0 reads as 1,
//   values above the maximum saturate). Any write restarts loading of the grid.
// After the last cell in_tready drops while the stored grid is scanned and
// flood filled out of a single-port cell memory and a single-port stack memory:
// each scanned cell is read and then checked, a land cell is marked visited and
// pushed, each pop reads the stack and then takes the popped cell, each neighbor
// inside the grid is read and checked while one outside it is skipped, and the
// region area is compared with the best when its stack runs empty. After the
// scan the block waits in the done state until the previous result is taken,
// then loads the registered result and returns to loading, so a stalled
// receiver only holds the block after the following grid is processed.
// Reset clears all control state and sets both sizes to 64; the memories are
// not cleared since every cell is written before it is read.
module max_island_area_flood_fill_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mif_pkg::IN_TDATA_W-1:0]     in_tdata,   // [0] cell_value
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mif_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [12:0] max_area
  input  logic                               cfg_we,
  input  logic [mif_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [mif_pkg::CFG_W-1:0]          cfg_data
);
  import mif_pkg::*;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]   rows_cfg_r, rows_cfg_nxt;
  logic [CFG_W-1:0]   cols_cfg_r, cols_cfg_nxt;
  logic [ROW_W-1:0]   rows_last;
  logic [COL_W-1:0]   cols_last;

  logic [ROW_W-1:0]   ld_row_r, ld_row_nxt;
  logic [COL_W-1:0]   ld_col_r, ld_col_nxt;
  logic [ROW_W-1:0]   scan_row_r, scan_row_nxt;
  logic [COL_W-1:0]   scan_col_r, scan_col_nxt;
  logic [ROW_W-1:0]   cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]   cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]   nb_row_r, nb_row_nxt;
  logic [COL_W-1:0]   nb_col_r, nb_col_nxt;
  logic [NB_W-1:0]    nb_k_r, nb_k_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [AREA_W-1:0]  area_r, area_nxt;
  logic [AREA_W-1:0]  best_r, best_nxt;
  logic [AREA_W-1:0]  out_area_r, out_area_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;

  logic [CELL_W-1:0]  cell_mem [CELL_DEPTH];
  logic [CELL_W-1:0]  cell_rd_r;
  logic               cell_we, cell_re;
  logic [ADDR_W-1:0]  cell_waddr, cell_raddr;
  logic [CELL_W-1:0]  cell_wdata;

  logic [ADDR_W-1:0]  stack_mem [STACK_DEPTH];
  logic [ADDR_W-1:0]  stack_rd_r;
  logic               stack_we, stack_re;
  logic [SP_W-1:0]    stack_waddr, stack_raddr;
  logic [ADDR_W-1:0]  stack_wdata;

  logic               nb_valid;
  logic [ROW_W-1:0]   nb_row;
  logic [COL_W-1:0]   nb_col;
  logic               scan_last;

  always_comb begin
    if (rows_cfg_r == '0) begin
      rows_last = '0;
    end else if (32'(rows_cfg_r) > MAX_ROWS) begin
      rows_last = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_last = ROW_W'(rows_cfg_r - 1'b1);
    end
    if (cols_cfg_r == '0) begin
      cols_last = '0;
    end else if (32'(cols_cfg_r) > MAX_COLS) begin
      cols_last = COL_W'(MAX_COLS - 1);
    end else begin
      cols_last = COL_W'(cols_cfg_r - 1'b1);
    end
  end

  assign scan_last = (scan_row_r == rows_last) && (scan_col_r == cols_last);

  always_comb begin
    nb_valid = 1'b0;
    nb_row   = cur_row_r;
    nb_col   = cur_col_r;
    case (nb_k_r)
      NB_DOWN: begin
        nb_valid = (cur_row_r != rows_last);
        nb_row   = cur_row_r + 1'b1;
      end
      NB_UP: begin
        nb_valid = (cur_row_r != '0);
        nb_row   = cur_row_r - 1'b1;
      end
      NB_RIGHT: begin
        nb_valid = (cur_col_r != cols_last);
        nb_col   = cur_col_r + 1'b1;
      end
      NB_LEFT: begin
        nb_valid = (cur_col_r != '0);
        nb_col   = cur_col_r - 1'b1;
      end
      default: begin
        nb_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    rows_cfg_nxt   = rows_cfg_r;
    cols_cfg_nxt   = cols_cfg_r;
    ld_row_nxt     = ld_row_r;
    ld_col_nxt     = ld_col_r;
    scan_row_nxt   = scan_row_r;
    scan_col_nxt   = scan_col_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    nb_row_nxt     = nb_row_r;
    nb_col_nxt     = nb_col_r;
    nb_k_nxt       = nb_k_r;
    depth_nxt      = depth_r;
    area_nxt       = area_r;
    best_nxt       = best_r;
    out_area_nxt   = out_area_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;

    cell_we     = 1'b0;
    cell_waddr  = {ld_row_r, ld_col_r};
    cell_wdata  = {1'b0, in_tdata[0]};
    cell_re     = 1'b0;
    cell_raddr  = {scan_row_r, scan_col_r};
    stack_we    = 1'b0;
    stack_waddr = depth_r[SP_W-1:0];
    stack_wdata = {scan_row_r, scan_col_r};
    stack_re    = 1'b0;
    stack_raddr = SP_W'(depth_r - 1'b1);

    in_tready = (state_r == ST_LOAD);

    case (state_r)
      ST_LOAD: begin
        if (in_tvalid) begin
          cell_we = 1'b1;
          if (ld_col_r == cols_last) begin
            ld_col_nxt = '0;
            if (ld_row_r == rows_last) begin
              ld_row_nxt   = '0;
              scan_row_nxt = '0;
              scan_col_nxt = '0;
              best_nxt     = '0;
              depth_nxt    = '0;
              state_nxt    = ST_SCAN_RD;
            end else begin
              ld_row_nxt = ld_row_r + 1'b1;
            end
          end else begin
            ld_col_nxt = ld_col_r + 1'b1;
          end
        end
      end
      ST_SCAN_RD: begin
        cell_re   = 1'b1;
        state_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (cell_rd_r == CELL_LAND) begin
          cell_we    = 1'b1;
          cell_waddr = {scan_row_r, scan_col_r};
          cell_wdata = CELL_VISITED;
          stack_we   = 1'b1;
          depth_nxt  = depth_r + 1'b1;
          area_nxt   = '0;
          state_nxt  = ST_POP;
        end else if (scan_last) begin
          state_nxt = ST_DONE;
        end else begin
          if (scan_col_r == cols_last) begin
            scan_col_nxt = '0;
            scan_row_nxt = scan_row_r + 1'b1;
          end else begin
            scan_col_nxt = scan_col_r + 1'b1;
          end
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_POP: begin
        if (depth_r != '0) begin
          stack_re  = 1'b1;
          depth_nxt = depth_r - 1'b1;
          state_nxt = ST_POP_WAIT;
        end else begin
          if (area_r > best_r) begin
            best_nxt = area_r;
          end
          if (scan_last) begin
            state_nxt = ST_DONE;
          end else begin
            if (scan_col_r == cols_last) begin
              scan_col_nxt = '0;
              scan_row_nxt = scan_row_r + 1'b1;
            end else begin
              scan_col_nxt = scan_col_r + 1'b1;
            end
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_POP_WAIT: begin
        cur_row_nxt = stack_rd_r[ADDR_W-1:COL_W];
        cur_col_nxt = stack_rd_r[COL_W-1:0];
        if (area_r != AREA_MAX) begin
          area_nxt = area_r + 1'b1;
        end
        nb_k_nxt  = NB_DOWN;
        state_nxt = ST_NB_RD;
      end
      ST_NB_RD: begin
        if (nb_k_r == NB_END) begin
          state_nxt = ST_POP;
        end else if (nb_valid) begin
          cell_re    = 1'b1;
          cell_raddr = {nb_row, nb_col};
          nb_row_nxt = nb_row;
          nb_col_nxt = nb_col;
          state_nxt  = ST_NB_CHK;
        end else begin
          nb_k_nxt = nb_k_r + 1'b1;
        end
      end
      ST_NB_CHK: begin
        if (cell_rd_r == CELL_LAND) begin
          cell_we     = 1'b1;
          cell_waddr  = {nb_row_r, nb_col_r};
          cell_wdata  = CELL_VISITED;
          stack_we    = 1'b1;
          stack_wdata = {nb_row_r, nb_col_r};
          depth_nxt   = depth_r + 1'b1;
        end
        nb_k_nxt  = nb_k_r + 1'b1;
        state_nxt = ST_NB_RD;
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_area_nxt   = best_r;
          best_nxt       = '0;
          state_nxt      = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    if (cfg_we) begin
      ld_row_nxt = '0;
      ld_col_nxt = '0;
      case (cfg_addr)
        REG_ROW_COUNT: rows_cfg_nxt = cfg_data;
        REG_COL_COUNT: cols_cfg_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      rows_cfg_r   <= CFG_SIZE_RESET;
      cols_cfg_r   <= CFG_SIZE_RESET;
      ld_row_r     <= '0;
      ld_col_r     <= '0;
      scan_row_r   <= '0;
      scan_col_r   <= '0;
      nb_k_r       <= NB_DOWN;
      depth_r      <= '0;
      area_r       <= '0;
      best_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rows_cfg_r   <= rows_cfg_nxt;
      cols_cfg_r   <= cols_cfg_nxt;
      ld_row_r     <= ld_row_nxt;
      ld_col_r     <= ld_col_nxt;
      scan_row_r   <= scan_row_nxt;
      scan_col_r   <= scan_col_nxt;
      nb_k_r       <= nb_k_nxt;
      depth_r      <= depth_nxt;
      area_r       <= area_nxt;
      best_r       <= best_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_row_r  <= cur_row_nxt;
    cur_col_r  <= cur_col_nxt;
    nb_row_r   <= nb_row_nxt;
    nb_col_r   <= nb_col_nxt;
    out_area_r <= out_area_nxt;
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cell_re) begin
      cell_rd_r <= cell_mem[cell_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    if (stack_re) begin
      stack_rd_r <= stack_mem[stack_raddr];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'(out_area_r);

endmodule
